FILE: src/tel_pkg.sv
// Shared constants and types for the trace event ring logger.
// Depends on nothing; imported by the logger module and the testbench.
package tel_pkg;

  localparam int DEPTH         = 1024;
  localparam int ADDR_W        = $clog2(DEPTH);
  localparam int RW_W          = ADDR_W + 1;
  localparam int TS_SHIFT      = 16;
  localparam int TS_FIELD_MAX  = 32767;
  localparam int WIDE_FLAG_BIT = 31;

  localparam int CNT_W      = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 56;

  localparam logic [31:0] WIDE_FLAG = 32'(1) << WIDE_FLAG_BIT;
  localparam logic [31:0] FIELD_MAX = 32'(TS_FIELD_MAX);
  localparam logic [63:0] HIGH_HALF = 64'hFFFF_FFFF_0000_0000;

  // item kinds carried on in_tuser
  localparam logic [1:0] MODE_BODY = 2'd0;
  localparam logic [1:0] MODE_LAST = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_AFTER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SHOT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_WORDS     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BODY,
    ST_HI,
    ST_LO,
    ST_TAG,
    ST_RD,
    ST_DONE
  } tel_state_t;

endpackage

FILE: src/trace_event_ring_logger.sv
// Trace event ring logger: circular trace buffer with delta timestamps.
// Single-port ring memory plus a small sequencer; uses tel_pkg.
//
// channel | direction | handshake           | payload
// in_     | input     | in_tvalid/in_tready | tuser: mode; tdata: data_word, timestamp, read_age
// out_    | output    | out_tvalid/tready   | tdata: one result per input transaction
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item goes idle to done if nothing is written, else via ST_BODY (body word), ST_RD (read)
// or ST_TAG (tag word) after any ST_HI/ST_LO; the single port does one write or read a cycle.
// A result waits in the output register while the next item is accepted.
// rst_n is synchronous; ring contents are not cleared and no clearing pass runs.
// Inputs and configuration are taken only in the idle state.
module trace_event_ring_logger
  import tel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_tuser,   // [1:0] mode
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] data_word, [95:32] timestamp,
                                            // [105:96] read_age, rest zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] read_word, [41:32] read_address,
                                            // [42] read_valid, [43] capturing,
                                            // [44] wrapped, [54:45] write_pointer, [55] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tel_state_t st_r, st_nxt;

  // ring memory
  logic [31:0]       ring_mem [DEPTH];
  logic [31:0]       mem_rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [31:0]       mem_wdata;

  // block state
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic              wrap_r, wrap_nxt;
  logic              en_r, en_nxt;
  logic [CNT_W-1:0]  start_r, start_nxt;
  logic [CNT_W-1:0]  stop_r, stop_nxt;
  logic              first_r, first_nxt;
  logic [63:0]       prev_r, prev_nxt;
  logic              in_msg_r, in_msg_nxt;
  logic              msg_cap_r, msg_cap_nxt;
  logic              one_shot_r, one_shot_nxt;
  logic [RW_W-1:0]   rw_r, rw_nxt;

  // item registers
  logic [1:0]        mode_r;
  logic [31:0]       data_r;
  logic [ADDR_W-1:0] age_r;
  logic [63:0]       delta_r;
  logic              wide_r, big_r, capt_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic              rd_valid_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic        in_acc, cfg_acc, slot_free;
  logic [1:0]  in_mode;
  logic [31:0] in_word;
  logic [63:0] in_ts;
  logic        first_word, cap_now;
  logic [63:0] delta_now;
  logic        wide_now, big_now;

  logic [RW_W-1:0]   ptr_ext, extra, age_ext, diff, rd_full;
  logic              rd_valid_now;
  logic [31:0]       sat_lo;
  logic [63:0]       sat_sh;
  logic [31:0]       tag_word;
  logic [RW_W-1:0]   wp_inc;
  logic [RW_W-1:0]   rw_cfg;
  logic [31:0]       res_word;
  logic [ADDR_W-1:0] res_addr;
  logic              res_valid;

  // a pending configuration write goes first; never take both in one cycle
  assign in_tready = (st_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign slot_free = !out_valid_r || out_tready;

  assign in_mode = in_tuser;
  assign in_word = in_tdata[31:0];
  assign in_ts   = in_tdata[95:32];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // first word of a message and the capture decision of the current message
  assign first_word = !in_mode[1] && !in_msg_r;
  assign delta_now  = first_r ? 64'd0 : in_ts - prev_r;
  assign wide_now   = (delta_now & HIGH_HALF) != 64'd0;
  assign big_now    = delta_now[31:0] >= FIELD_MAX;

  always_comb begin
    logic en_mid;
    en_mid      = en_r;
    start_nxt   = start_r;
    stop_nxt    = stop_r;
    first_nxt   = first_r;
    prev_nxt    = prev_r;
    in_msg_nxt  = in_msg_r;
    msg_cap_nxt = msg_cap_r;
    one_shot_nxt = one_shot_r;
    rw_nxt      = rw_r;
    cap_now     = msg_cap_r;
    if (in_acc && first_word) begin
      if (!start_r[CNT_W-1]) begin
        if (start_r == '0) begin
          en_mid = 1'b1;
        end
        start_nxt = start_r - CNT_W'(1);
      end
      cap_now     = en_mid && !(one_shot_r && wrap_r);
      msg_cap_nxt = cap_now;
      in_msg_nxt  = 1'b1;
    end
    en_nxt = en_mid;
    if (in_acc && in_mode == MODE_LAST) begin
      in_msg_nxt = 1'b0;
      if (cap_now) begin
        first_nxt = 1'b0;
        prev_nxt  = in_ts;
        if (!stop_r[CNT_W-1] && en_mid) begin
          stop_nxt = stop_r - CNT_W'(1);
          if (stop_r == CNT_W'(1)) begin
            en_nxt = 1'b0;
          end
        end
      end
    end
    // configuration writes arrive only while idle
    rw_cfg = cfg_data[RW_W-1:0];
    if (rw_cfg == '0) begin
      rw_cfg = RW_W'(1);
    end else if (rw_cfg > RW_W'(DEPTH)) begin
      rw_cfg = RW_W'(DEPTH);
    end
    if (cfg_acc) begin
      unique case (cfg_index)
        CFG_CAPTURE_ENABLE: en_nxt = cfg_data[0];
        CFG_START_DELAY: begin
          en_nxt    = 1'b0;
          start_nxt = cfg_data[CNT_W-1:0];
        end
        CFG_STOP_AFTER: stop_nxt     = cfg_data[CNT_W-1:0];
        CFG_ONE_SHOT:   one_shot_nxt = cfg_data[0];
        CFG_RING_WORDS: rw_nxt       = rw_cfg;
        default: ;
      endcase
    end
  end

  // read address for a given age, newest first
  always_comb begin
    ptr_ext      = {1'b0, wp_r};
    age_ext      = {1'b0, age_r};
    extra        = (wrap_r && rw_r > ptr_ext) ? rw_r - ptr_ext : '0;
    diff         = age_ext - ptr_ext;
    rd_full      = '0;
    rd_valid_now = 1'b0;
    if (age_ext < ptr_ext) begin
      rd_full      = ptr_ext - RW_W'(1) - age_ext;
      rd_valid_now = 1'b1;
    end else if (diff < extra) begin
      rd_full      = rw_r - RW_W'(1) - diff;
      rd_valid_now = 1'b1;
    end
  end

  // tag word with the saturated delta
  always_comb begin
    sat_lo   = (wide_r || big_r) ? FIELD_MAX : delta_r[31:0];
    sat_sh   = 64'(sat_lo) << TS_SHIFT;
    tag_word = data_r | (wide_r ? WIDE_FLAG : 32'd0) | sat_sh[31:0];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_BODY: st_nxt = cap_now ? ST_BODY : ST_DONE;
            MODE_LAST: begin
              priority if (!cap_now) st_nxt = ST_DONE;
              else if (wide_now)     st_nxt = ST_HI;
              else if (big_now)      st_nxt = ST_LO;
              else                   st_nxt = ST_TAG;
            end
            MODE_READ: st_nxt = ST_RD;
            default:   st_nxt = ST_DONE;
          endcase
        end
      end
      ST_BODY: st_nxt = ST_DONE;
      ST_HI:   st_nxt = ST_LO;
      ST_LO:   st_nxt = ST_TAG;
      ST_TAG:  st_nxt = ST_DONE;
      ST_RD:   st_nxt = ST_DONE;
      ST_DONE: st_nxt = slot_free ? ST_IDLE : ST_DONE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // memory port, pointer advance and result
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = wp_r;
    mem_wdata = data_r;
    unique case (st_r)
      ST_BODY: begin
        mem_we = 1'b1;
      end
      ST_HI: begin
        mem_we    = 1'b1;
        mem_wdata = delta_r[63:32];
      end
      ST_LO: begin
        mem_we    = 1'b1;
        mem_wdata = delta_r[31:0];
      end
      ST_TAG: begin
        mem_we    = 1'b1;
        mem_wdata = tag_word;
      end
      ST_RD: begin
        mem_re   = 1'b1;
        mem_addr = rd_full[ADDR_W-1:0];
      end
      default: ;
    endcase

    wp_inc   = {1'b0, wp_r} + RW_W'(1);
    wp_nxt   = wp_r;
    wrap_nxt = wrap_r;
    if (mem_we) begin
      if (wp_inc >= rw_r) begin
        wp_nxt   = '0;
        wrap_nxt = 1'b1;
      end else begin
        wp_nxt = wp_inc[ADDR_W-1:0];
      end
    end

    res_valid = (mode_r == MODE_READ) && rd_valid_r;
    res_word  = res_valid ? mem_rdata_r : 32'd0;
    res_addr  = res_valid ? rd_addr_r : '0;

    out_valid_nxt = out_valid_r && !out_tready;
    if (st_r == ST_DONE && slot_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= ring_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wp_r        <= '0;
      wrap_r      <= 1'b0;
      en_r        <= 1'b1;
      start_r     <= '1;
      stop_r      <= '1;
      first_r     <= 1'b1;
      prev_r      <= '0;
      in_msg_r    <= 1'b0;
      msg_cap_r   <= 1'b0;
      one_shot_r  <= 1'b0;
      rw_r        <= RW_W'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      wp_r        <= wp_nxt;
      wrap_r      <= wrap_nxt;
      en_r        <= en_nxt;
      start_r     <= start_nxt;
      stop_r      <= stop_nxt;
      first_r     <= first_nxt;
      prev_r      <= prev_nxt;
      in_msg_r    <= in_msg_nxt;
      msg_cap_r   <= msg_cap_nxt;
      one_shot_r  <= one_shot_nxt;
      rw_r        <= rw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_mode;
      data_r  <= in_word;
      age_r   <= in_tdata[96 +: ADDR_W];
      delta_r <= delta_now;
      wide_r  <= wide_now;
      big_r   <= big_now;
      if (!in_mode[1]) begin
        capt_r <= cap_now;
      end else if (in_mode == MODE_READ) begin
        capt_r <= in_msg_r && msg_cap_r;
      end else begin
        capt_r <= 1'b0;
      end
      rd_valid_r <= 1'b0;
    end
    if (st_r == ST_RD) begin
      rd_addr_r  <= rd_full[ADDR_W-1:0];
      rd_valid_r <= rd_valid_now;
    end
    if (st_r == ST_DONE && slot_free) begin
      out_data_r <= {1'b0, wp_r, wrap_r, capt_r, res_valid, res_addr, res_word};
    end
  end

  // the pointer always lands inside the ring after a write
  a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> ({1'b0, wp_r} < rw_r))
    else $error("write pointer outside ring after write");

  // single port: never a read and a write together
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("ring read and write in the same cycle");

  // a wide delta always writes the low word next
  a_hi_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_HI) |=> (st_r == ST_LO))
    else $error("high delta word not followed by low word");

  // a finished item lands in the output register when the slot is free
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && slot_free) |=> (out_valid_r && st_r == ST_IDLE))
    else $error("result not loaded");

  // once wrapped, stays wrapped
  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_r |=> wrap_r)
    else $error("wrap flag cleared");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for trace_event_ring_logger: drives trace messages, reads and
// configuration writes and checks every result against a built-in model of the ring.
// Depends on tel_pkg and the trace_event_ring_logger RTL.
module tb_top
  import tel_pkg::*;
();

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int HOLD_CYCLES = 80;

  // packed in the order of out_tdata[54:0]
  typedef struct packed {
    logic [ADDR_W-1:0] wptr;
    logic              wrapped;
    logic              capturing;
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       word;
  } log_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [1:0]            in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // model of the logger state
  logic [31:0] ring_mem [DEPTH];
  bit          ring_written [DEPTH];
  int unsigned wr_ptr = 0;
  bit          wrap_seen = 1'b0;
  bit          capture_on = 1'b1;
  int          start_left = -1;
  int          stop_left = -1;
  bit          first_tag = 1'b1;
  logic [63:0] last_stamp = '0;
  bit          in_msg = 1'b0;
  bit          msg_kept = 1'b0;
  bit          one_shot_set = 1'b0;
  int unsigned ring_words = DEPTH;

  log_result_t pending_results [$];
  int unsigned fail_count = 0;
  int unsigned items_counted = 0;
  logic [63:0] stamp_clock = '0;
  bit          steady_flow = 1'b0;
  bit          hold_request = 1'b0;

  trace_event_ring_logger uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void store_word(input logic [31:0] w);
    int unsigned p;
    p = wr_ptr % DEPTH;
    ring_mem[p] = w;
    ring_written[p] = 1'b1;
    p++;
    if (p >= ring_words) begin
      p = 0;
      wrap_seen = 1'b1;
    end
    wr_ptr = p;
  endfunction

  // map a read age to a ring address, newest first, including the wrapped tail
  function automatic void ring_lookup(input logic [ADDR_W-1:0] age, output logic ok,
                                      output logic [ADDR_W-1:0] addr);
    int unsigned ptr, extra, a;
    ptr = wr_ptr % DEPTH;
    extra = 0;
    a = age;
    ok = 1'b0;
    addr = '0;
    if (wrap_seen && ring_words > ptr) extra = ring_words - ptr;
    if (a < ptr) begin
      addr = ADDR_W'(ptr - 1 - a);
      ok = 1'b1;
    end else if (a - ptr < extra) begin
      addr = ADDR_W'(ring_words - 1 - (a - ptr));
      ok = 1'b1;
    end
  endfunction

  function automatic log_result_t predict_log_step(input logic [1:0] mode,
                                                   input logic [31:0] data,
                                                   input logic [63:0] stamp,
                                                   input logic [ADDR_W-1:0] age);
    log_result_t r;
    logic [63:0] delta;
    logic [31:0] flag;
    r = '0;
    if (mode == MODE_BODY || mode == MODE_LAST) begin
      if (!in_msg) begin
        if (start_left >= 0) begin
          if (start_left == 0) capture_on = 1'b1;
          start_left--;
        end
        msg_kept = capture_on && !(one_shot_set && wrap_seen);
        in_msg = 1'b1;
      end
      r.capturing = msg_kept;
      if (mode == MODE_BODY) begin
        if (msg_kept) store_word(data);
      end else begin
        if (msg_kept) begin
          delta = first_tag ? 64'd0 : stamp - last_stamp;
          flag = '0;
          first_tag = 1'b0;
          last_stamp = stamp;
          if ((delta & HIGH_HALF) != 0) begin
            store_word(delta[63:32]);
            store_word(delta[31:0]);
            flag = WIDE_FLAG;
            delta = 64'(TS_FIELD_MAX);
          end else if (delta >= FIELD_MAX) begin
            store_word(delta[31:0]);
            delta = 64'(TS_FIELD_MAX);
          end
          store_word(data | flag | 32'(delta << TS_SHIFT));
          if (stop_left >= 0 && capture_on) begin
            stop_left--;
            if (stop_left == 0) capture_on = 1'b0;
          end
        end
        in_msg = 1'b0;
      end
    end else if (mode == MODE_READ) begin
      r.capturing = in_msg && msg_kept;
      ring_lookup(age, r.valid, r.addr);
      if (r.valid) r.word = ring_mem[r.addr];
    end
    r.wrapped = wrap_seen;
    r.wptr = ADDR_W'(wr_ptr);
    return r;
  endfunction

  // pick an age that never lands on a ring word left unwritten
  function automatic bit pick_read_age(output logic [ADDR_W-1:0] age);
    logic ok;
    logic [ADDR_W-1:0] addr;
    for (int t = 0; t < 8; t++) begin
      age = $urandom_range(1) ? ADDR_W'($urandom_range(0, 40)) : ADDR_W'($urandom);
      ring_lookup(age, ok, addr);
      if (!ok || ring_written[addr]) return 1'b1;
    end
    for (int a = 0; a < DEPTH; a++) begin
      age = ADDR_W'(a);
      ring_lookup(age, ok, addr);
      if (!ok || ring_written[addr]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [63:0] next_timestamp();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) stamp_clock += 64'($urandom_range(0, 2000));
    else if (pick < 55) stamp_clock += 64'(TS_FIELD_MAX - 2 + $urandom_range(0, 4));
    else if (pick < 70) stamp_clock += 64'($urandom);
    else if (pick < 80) stamp_clock += {28'd0, 4'($urandom_range(1, 15)), 32'($urandom)};
    else if (pick < 88) stamp_clock += 64'h1_0000_0000 - 64'($urandom_range(0, 1));
    else stamp_clock = {$urandom, $urandom};
    return stamp_clock;
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [31:0] data,
                           input logic [63:0] stamp, input logic [ADDR_W-1:0] age);
    @(negedge clk);
    if (!steady_flow && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'd0, age, stamp, data};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_log_step(mode, data, stamp, age));
    if (mode != MODE_NONE) items_counted++;
  endtask

  // drop valid and hold until every outstanding result has been taken
  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] bits;
    int unsigned n;
    bits = CFG_DATA_W'(val);
    wait_all_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bits;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CAPTURE_ENABLE: capture_on = bits[0];
      CFG_START_DELAY: begin
        capture_on = 1'b0;
        start_left = {{(32 - CFG_DATA_W){bits[CFG_DATA_W-1]}}, bits};
      end
      CFG_STOP_AFTER: stop_left = {{(32 - CFG_DATA_W){bits[CFG_DATA_W-1]}}, bits};
      CFG_ONE_SHOT: one_shot_set = bits[0];
      CFG_RING_WORDS: begin
        n = bits[RW_W-1:0];
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        ring_words = n;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_read();
    logic [ADDR_W-1:0] age;
    if (pick_read_age(age)) send_item(MODE_READ, $urandom, {$urandom, $urandom}, age);
    else send_item(MODE_NONE, $urandom, {$urandom, $urandom}, ADDR_W'($urandom));
  endtask

  task automatic send_message(input int unsigned n_body);
    for (int i = 0; i < n_body; i++) begin
      if ($urandom_range(99) < 8) send_read();
      send_item(MODE_BODY, $urandom, {$urandom, $urandom}, ADDR_W'($urandom));
    end
    send_item(MODE_LAST, $urandom, next_timestamp(), ADDR_W'($urandom));
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned start_count, pick;
    start_count = items_counted;
    while (items_counted - start_count < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_message(($urandom_range(9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3));
      end else if (pick < 88) begin
        send_read();
      end else if (pick < 94) begin
        send_item(MODE_NONE, $urandom, {$urandom, $urandom}, ADDR_W'($urandom));
      end else begin
        // leave a message open across noise and a read; the next words join it
        send_item(MODE_BODY, $urandom, {$urandom, $urandom}, ADDR_W'($urandom));
        send_item(MODE_NONE, $urandom, {$urandom, $urandom}, ADDR_W'($urandom));
        send_read();
      end
    end
  endtask

  task automatic test_field_extremes();
    send_item(MODE_READ, 32'h0, 64'h0, 10'd0);
    send_item(MODE_READ, 32'hFFFF_FFFF, '1, 10'h3FF);
    send_item(MODE_NONE, 32'hFFFF_FFFF, '1, 10'h3FF);
    send_item(MODE_BODY, 32'h0, 64'h0, 10'd0);
    send_item(MODE_BODY, 32'hFFFF_FFFF, '1, 10'h3FF);
    send_item(MODE_READ, 32'h0, 64'h0, 10'd0);
    send_item(MODE_NONE, 32'h0, 64'h0, 10'd0);
    // first captured tag carries a zero delta
    send_item(MODE_LAST, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
    send_item(MODE_LAST, 32'hFFFF_FFFF, 64'd32765, 10'h3FF);
    send_item(MODE_LAST, 32'h1234_5678, 64'd65532, 10'd0);
    send_item(MODE_LAST, 32'h0, 64'd65532 + 64'hFFFF_FFFF, 10'd0);
    send_item(MODE_LAST, 32'h0, 64'd65532 + 64'hFFFF_FFFF + 64'h1_0000_0000, 10'd0);
    send_item(MODE_LAST, 32'hA5A5_A5A5, 64'h0, 10'd0);
    send_item(MODE_LAST, 32'h5A5A_5A5A, 64'h0, 10'd0);
    send_item(MODE_READ, 32'h0, 64'h0, 10'd0);
    send_item(MODE_READ, 32'h0, 64'h0, 10'd14);
    send_item(MODE_READ, 32'h0, 64'h0, 10'd15);
  endtask

  task automatic test_ring_limits();
    // one-word ring while the pointer sits beyond it
    write_reg(CFG_RING_WORDS, 0);
    run_traffic(15);
    // clamps to full depth; the ring grows after a wrap
    write_reg(CFG_RING_WORDS, 2047);
    run_traffic(20);
    write_reg(CFG_RING_WORDS, 6);
    run_traffic(25);
  endtask

  task automatic test_capture_control();
    write_reg(CFG_RING_WORDS, 64);
    write_reg(CFG_START_DELAY, 0);
    run_traffic(10);
    write_reg(CFG_START_DELAY, 3);
    write_reg(CFG_STOP_AFTER, 2);
    run_traffic(30);
    write_reg(CFG_STOP_AFTER, 0);
    write_reg(CFG_CAPTURE_ENABLE, 1);
    run_traffic(15);
    // a write between words of a message must not change its capture decision
    send_item(MODE_BODY, $urandom, {$urandom, $urandom}, ADDR_W'($urandom));
    write_reg(CFG_CAPTURE_ENABLE, 0);
    send_item(MODE_LAST, $urandom, next_timestamp(), ADDR_W'($urandom));
    send_message(2);
    write_reg(CFG_START_DELAY, 1048575);
    write_reg(CFG_STOP_AFTER, 1048575);
    write_reg(CFG_CAPTURE_ENABLE, 1);
    run_traffic(15);
    // wrap already seen, so one-shot blocks every new message
    write_reg(CFG_ONE_SHOT, 1);
    run_traffic(15);
    write_reg(CFG_ONE_SHOT, 0);
    write_reg(CFG_STOP_AFTER, -1);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    send_message(12);
    run_traffic(10);
  endtask

  task automatic test_drain_pause();
    send_item(MODE_BODY, $urandom, {$urandom, $urandom}, ADDR_W'($urandom));
    send_item(MODE_BODY, $urandom, {$urandom, $urandom}, ADDR_W'($urandom));
    wait_all_results();
    send_item(MODE_LAST, $urandom, next_timestamp(), ADDR_W'($urandom));
    run_traffic(10);
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    for (int ph = 0; ph < 6; ph++) begin
      pick = $urandom_range(2);
      write_reg(CFG_RING_WORDS, (pick == 0) ? $urandom_range(1, 16) :
                                (pick == 1) ? $urandom_range(17, 1023) : DEPTH);
      write_reg(CFG_ONE_SHOT, $urandom_range(99) < 20);
      write_reg(CFG_STOP_AFTER, $urandom_range(1) ? -1 : int'($urandom_range(0, 25)));
      if ($urandom_range(1)) begin
        write_reg(CFG_START_DELAY, $urandom_range(0, 4));
      end else begin
        write_reg(CFG_START_DELAY, -1);
        write_reg(CFG_CAPTURE_ENABLE, 1);
      end
      steady_flow = (ph == 2);
      run_traffic(20);
    end
    steady_flow = 1'b0;
  endtask

  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_tready <= steady_flow || ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin : check_results
    log_result_t got;
    log_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = log_result_t'(out_tdata[54:0]);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("[%0t] result with none expected: %h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.word !== want.word || got.addr !== want.addr || got.valid !== want.valid ||
            got.capturing !== want.capturing || got.wrapped !== want.wrapped ||
            got.wptr !== want.wptr) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"[%0t] mismatch exp/got: word %h/%h addr %0d/%0d valid %b/%b",
                      " capturing %b/%b wrapped %b/%b write_pointer %0d/%0d"},
                     $time, want.word, got.word, want.addr, got.addr, want.valid, got.valid,
                     want.capturing, got.capturing, want.wrapped, got.wrapped,
                     want.wptr, got.wptr);
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = '0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_ring_limits();
    test_capture_control();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();

    wait_all_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: trace_event_ring_logger.f
src/tel_pkg.sv
src/trace_event_ring_logger.sv
tb/tb_top.sv
